@@ rtl/core/dlq_pkg.sv @@
// Shared types, codes and constants of the delta-list timer queue.
package dlq_pkg;

   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int ARG_WIDTH_DEF   = 32;
   localparam int MAX_RESULTS     = 32;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_TICK   = 2'd2,
      OP_EXPIRE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_RSVD      = 2'd3
   } status_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [15:0]        handle;
      logic [31:0]        argument;
      logic signed [31:0] delay_ticks;
   } req_item_type;

   typedef struct packed {
      status_type         status;
      logic               due_flag;
      logic               entry_valid;
      logic [15:0]        out_handle;
      logic [31:0]        out_argument;
      logic signed [31:0] lateness;
      logic               last;
   } rsp_item_type;

   // Signed 33-bit result clamped back into 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/core/dlq_cell.sv @@
// One storage cell of the queue ring: holds an entry and passes it on when shifted.
module dlq_cell #(
   parameter int ARG_WIDTH = dlq_pkg::ARG_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 shift_en,
   input  logic [15:0]          in_handle,
   input  logic [ARG_WIDTH-1:0] in_arg,
   input  logic signed [31:0]   in_delta,
   output logic [15:0]          out_handle,
   output logic [ARG_WIDTH-1:0] out_arg,
   output logic signed [31:0]   out_delta
);

   logic [15:0]          handle_ff;
   logic [ARG_WIDTH-1:0] arg_ff;
   logic signed [31:0]   delta_ff;

   // Payload only, no reset: entries beyond the fill count are never used.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         handle_ff <= in_handle;
         arg_ff    <= in_arg;
         delta_ff  <= in_delta;
      end
   end

   assign out_handle = handle_ff;
   assign out_arg    = arg_ff;
   assign out_delta  = delta_ff;

endmodule

@@ rtl/core/dlq_ctrl.sv @@
// Queue controller: handshakes, fill count and the per-cycle edit of the rotating ring.
module dlq_ctrl #(
   parameter int QUEUE_DEPTH = dlq_pkg::QUEUE_DEPTH_DEF,
   parameter int ARG_WIDTH   = dlq_pkg::ARG_WIDTH_DEF,
   localparam int IDX_W      = $clog2(QUEUE_DEPTH),
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dlq_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dlq_pkg::rsp_item_type rsp_item,
   output logic                  shift_en,
   output logic [15:0]           emit_handle,
   output logic [ARG_WIDTH-1:0]  emit_arg,
   output logic signed [31:0]    emit_delta,
   input  logic [15:0]           head_handle,
   input  logic [ARG_WIDTH-1:0]  head_arg,
   input  logic signed [31:0]    head_delta,
   input  logic [15:0]           next_handle,
   input  logic [ARG_WIDTH-1:0]  next_arg,
   input  logic signed [31:0]    next_delta,
   output logic [CNT_W-1:0]      entry_count
);

   localparam int NPOP_W = $clog2(dlq_pkg::MAX_RESULTS + 1);
   localparam logic [IDX_W-1:0] LAST_CYC = IDX_W'(QUEUE_DEPTH - 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_PASS = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   dlq_pkg::opcode_type   op_ff, op_in;
   logic [IDX_W-1:0]      cyc_ff, cyc_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  done_ff, done_in;
   logic                  walk_ff, walk_in;
   logic                  due_ff, due_in;
   logic signed [31:0]    t_ff, t_in;
   logic [15:0]           key_h_ff, key_h_in;
   logic [ARG_WIDTH-1:0]  key_a_ff, key_a_in;
   logic [15:0]           car_h_ff, car_h_in;
   logic [ARG_WIDTH-1:0]  car_a_ff, car_a_in;
   logic signed [31:0]    car_d_ff, car_d_in;
   logic [NPOP_W-1:0]     npop_ff, npop_in;
   dlq_pkg::rsp_item_type res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   dlq_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic [ARG_WIDTH-1:0]  req_arg;
   logic [31:0]           head_arg32;
   logic                  head_v, next_v, head_due, more;
   logic signed [31:0]    dec_delta;
   dlq_pkg::rsp_item_type pop_res;

   // Argument width conversion between ports and storage
   generate
      if (ARG_WIDTH >= 32) begin : g_wide
         assign req_arg    = ARG_WIDTH'(req_item.argument);
         assign head_arg32 = head_arg[31:0];
      end else begin : g_narrow
         assign req_arg    = req_item.argument[ARG_WIDTH-1:0];
         assign head_arg32 = {{(32 - ARG_WIDTH){1'b0}}, head_arg};
      end
   endgenerate

   // Position of the pass against the fill count
   assign head_v    = {1'b0, cyc_ff} < {1'b0, count_ff};
   assign next_v    = ({1'b0, cyc_ff} + 1'b1) < {1'b0, count_ff};
   assign head_due  = (count_ff != '0) && (head_delta <= 0);
   assign dec_delta = dlq_pkg::sat32({head_delta[31], head_delta} - 33'sd1);
   assign more      = (op_ff == dlq_pkg::OP_EXPIRE) && res_ff.entry_valid && head_due &&
                      (npop_ff < NPOP_W'(dlq_pkg::MAX_RESULTS));

   always_comb begin
      pop_res              = '0;
      pop_res.entry_valid  = 1'b1;
      pop_res.out_handle   = head_handle;
      pop_res.out_argument = head_arg32;
      pop_res.lateness     = head_delta;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cyc_in       = cyc_ff;
      count_in     = count_ff;
      done_in      = done_ff;
      walk_in      = walk_ff;
      due_in       = due_ff;
      t_in         = t_ff;
      key_h_in     = key_h_ff;
      key_a_in     = key_a_ff;
      car_h_in     = car_h_ff;
      car_a_in     = car_a_ff;
      car_d_in     = car_d_ff;
      npop_in      = npop_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      shift_en     = 1'b0;
      emit_handle  = head_handle;
      emit_arg     = head_arg;
      emit_delta   = head_delta;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_item.opcode;
               key_h_in = req_item.handle;
               key_a_in = req_arg;
               t_in     = (req_item.delay_ticks <= 0) ? 32'sd1 : req_item.delay_ticks;
               cyc_in   = '0;
               done_in  = 1'b0;
               walk_in  = 1'b1;
               due_in   = 1'b0;
               npop_in  = '0;
               res_in   = '0;
               state_in = S_PASS;
               case (req_item.opcode)
                  dlq_pkg::OP_INSERT: begin
                     if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
                        res_in.status = dlq_pkg::ST_FULL;
                        state_in      = S_EMIT;
                     end
                  end
                  dlq_pkg::OP_EXPIRE: begin
                     if (head_due) begin
                        res_in  = pop_res;
                        npop_in = NPOP_W'(1);
                     end else begin
                        state_in = S_EMIT;
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_PASS: begin
            shift_en = 1'b1;
            case (op_ff)
               // Walk past earlier entries, then drop in the new one and delay the rest
               dlq_pkg::OP_INSERT: begin
                  if (done_ff) begin
                     emit_handle = car_h_ff;
                     emit_arg    = car_a_ff;
                     emit_delta  = car_d_ff;
                     car_h_in    = head_handle;
                     car_a_in    = head_arg;
                     car_d_in    = head_delta;
                  end else if (head_v && head_delta < t_ff) begin
                     if (head_delta > 0) begin
                        t_in = t_ff - head_delta;
                     end
                  end else begin
                     emit_handle = key_h_ff;
                     emit_arg    = key_a_ff;
                     emit_delta  = t_ff;
                     car_h_in    = head_handle;
                     car_a_in    = head_arg;
                     car_d_in    = head_delta - t_ff;
                     done_in     = 1'b1;
                  end
               end
               // Close the gap by reading one cell ahead
               dlq_pkg::OP_REMOVE, dlq_pkg::OP_EXPIRE: begin
                  if (done_ff) begin
                     emit_handle = next_handle;
                     emit_arg    = next_arg;
                     emit_delta  = next_delta;
                  end else if ((op_ff == dlq_pkg::OP_EXPIRE) ? (cyc_ff == '0) :
                               (head_v && head_handle == key_h_ff && head_arg == key_a_ff)) begin
                     done_in     = 1'b1;
                     emit_handle = next_handle;
                     emit_arg    = next_arg;
                     emit_delta  = next_delta;
                     if (op_ff == dlq_pkg::OP_REMOVE && next_v && head_delta > 0) begin
                        emit_delta = dlq_pkg::sat32({next_delta[31], next_delta} +
                                                    {head_delta[31], head_delta});
                     end
                  end
               end
               // Decrement the head and any overdue run behind it
               default: begin
                  if (walk_ff && head_v) begin
                     emit_delta = dec_delta;
                     if (dec_delta > 0) begin
                        walk_in = 1'b0;
                     end else begin
                        due_in = 1'b1;
                        if (dec_delta == 0) begin
                           walk_in = 1'b0;
                        end
                     end
                  end
               end
            endcase

            cyc_in = cyc_ff + 1'b1;
            if (cyc_ff == LAST_CYC) begin
               cyc_in   = '0;
               state_in = S_EMIT;
               case (op_ff)
                  dlq_pkg::OP_INSERT: count_in = count_ff + 1'b1;
                  dlq_pkg::OP_REMOVE: begin
                     if (done_in) begin
                        count_in = count_ff - 1'b1;
                     end else begin
                        res_in.status = dlq_pkg::ST_NOT_FOUND;
                     end
                  end
                  dlq_pkg::OP_TICK: res_in.due_flag = due_in;
                  default: count_in = count_ff - 1'b1;
               endcase
            end
         end

         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_item_in      = res_ff;
               rsp_item_in.last = !more;
               if (more) begin
                  res_in   = pop_res;
                  npop_in  = npop_ff + 1'b1;
                  done_in  = 1'b0;
                  cyc_in   = '0;
                  state_in = S_PASS;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cyc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cyc_ff       <= cyc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers of the current item
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      done_ff     <= done_in;
      walk_ff     <= walk_in;
      due_ff      <= due_in;
      t_ff        <= t_in;
      key_h_ff    <= key_h_in;
      key_a_ff    <= key_a_in;
      car_h_ff    <= car_h_in;
      car_a_ff    <= car_a_in;
      car_d_ff    <= car_d_in;
      npop_ff     <= npop_in;
      res_ff      <= res_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_item    = rsp_item_ff;
   assign entry_count = count_ff;

endmodule

@@ rtl/core/delta_list_timer_queue.sv @@
// Top level of the delta-list timer queue: controller plus a ring of entry cells.
//
// Usage: items enter on req_valid/req_ready carrying an opcode (insert, remove,
// tick, expire), handle, argument and delay. Results leave on rsp_valid/rsp_ready.
// Insert, remove and tick give one result each. Expire gives one result per popped
// due entry (up to 32), or a single empty result, with last set on the final one.
// Entries live in a ring of QUEUE_DEPTH cells that rotates one place per cycle
// while an item's pass is under way. Every insert, remove and tick (and every
// expire pop) makes one full turn of the ring before its result is issued.
// A full insert or an expire with nothing due skips the turn.
// req_ready is high only between items. A result waits in the output register
// while the receiver stalls; an expire with more due entries holds until the
// previous result is taken. Reset empties the queue.
module delta_list_timer_queue #(
   parameter int QUEUE_DEPTH = dlq_pkg::QUEUE_DEPTH_DEF,
   parameter int ARG_WIDTH   = dlq_pkg::ARG_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dlq_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dlq_pkg::rsp_item_type rsp_item
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic                 shift_en;
   logic [15:0]          emit_handle;
   logic [ARG_WIDTH-1:0] emit_arg;
   logic signed [31:0]   emit_delta;
   logic [CNT_W-1:0]     entry_count;

   logic [15:0]          cell_handle [QUEUE_DEPTH];
   logic [ARG_WIDTH-1:0] cell_arg    [QUEUE_DEPTH];
   logic signed [31:0]   cell_delta  [QUEUE_DEPTH];

   dlq_ctrl #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .ARG_WIDTH  (ARG_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item),
      .shift_en   (shift_en),
      .emit_handle(emit_handle),
      .emit_arg   (emit_arg),
      .emit_delta (emit_delta),
      .head_handle(cell_handle[0]),
      .head_arg   (cell_arg[0]),
      .head_delta (cell_delta[0]),
      .next_handle(cell_handle[1]),
      .next_arg   (cell_arg[1]),
      .next_delta (cell_delta[1]),
      .entry_count(entry_count)
   );

   // Ring of cells: each takes its upper neighbor, the top one takes the controller
   generate
      for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         if (i == QUEUE_DEPTH - 1) begin : g_top
            dlq_cell #(.ARG_WIDTH(ARG_WIDTH)) u_cell (
               .clock     (clock),
               .shift_en  (shift_en),
               .in_handle (emit_handle),
               .in_arg    (emit_arg),
               .in_delta  (emit_delta),
               .out_handle(cell_handle[i]),
               .out_arg   (cell_arg[i]),
               .out_delta (cell_delta[i])
            );
         end else begin : g_mid
            dlq_cell #(.ARG_WIDTH(ARG_WIDTH)) u_cell (
               .clock     (clock),
               .shift_en  (shift_en),
               .in_handle (cell_handle[i+1]),
               .in_arg    (cell_arg[i+1]),
               .in_delta  (cell_delta[i+1]),
               .out_handle(cell_handle[i]),
               .out_arg   (cell_arg[i]),
               .out_delta (cell_delta[i])
            );
         end
      end
   endgenerate

   // Fill count never passes the ring size
   assert property (@(posedge clock) disable iff (reset)
      entry_count <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

   // An accepted item keeps the input closed in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input reopened right after accept");

   // A non-final result means the same item is still being worked on
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_item.last |-> !req_ready)
      else $error("input open while expire results are pending");

   // Ring only turns while the input is closed
   assert property (@(posedge clock) disable iff (reset)
      shift_en |-> !req_ready)
      else $error("ring rotating while idle");

endmodule

@@ tb/sv/delta_list_timer_queue_tb.sv @@
// Self-checking testbench of the delta-list timer queue: random and directed traffic.
module delta_list_timer_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = 32;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   dlq_pkg::req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   dlq_pkg::rsp_item_type rsp_item;

   delta_list_timer_queue u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the timer queue
   logic [15:0]        q_handle[DEPTH];
   logic [31:0]        q_arg[DEPTH];
   logic signed [31:0] q_delta[DEPTH];
   int                 q_count = 0;

   dlq_pkg::req_item_type pending_items[$];
   dlq_pkg::rsp_item_type expected_rsps[$];
   int  error_count = 0;
   int  idle_cycles = 0;
   int  items_sent = 0;
   int  rsps_seen = 0;
   int  pops_seen = 0;
   bit  stim_done = 1'b0;

   function automatic logic signed [31:0] clamp32(longint v);
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      return v[31:0];
   endfunction

   function automatic void shift_down(int from);
      for (int j = from; j + 1 < q_count; j++) begin
         q_handle[j] = q_handle[j + 1];
         q_arg[j]    = q_arg[j + 1];
         q_delta[j]  = q_delta[j + 1];
      end
      q_count--;
   endfunction

   // Advance the shadow queue by one item and queue the results it causes
   function automatic void predict_timer_op(dlq_pkg::req_item_type it);
      dlq_pkg::rsp_item_type r;
      longint t;
      int i;
      int n;
      r = '0;
      r.last = 1'b1;
      case (it.opcode)
         dlq_pkg::OP_INSERT: begin
            if (q_count >= DEPTH) begin
               r.status = dlq_pkg::ST_FULL;
            end else begin
               t = it.delay_ticks;
               if (t <= 0) t = 1;
               i = 0;
               while (i < q_count && q_delta[i] < t) begin
                  if (q_delta[i] > 0) t -= q_delta[i];
                  i++;
               end
               for (int j = q_count; j > i; j--) begin
                  q_handle[j] = q_handle[j - 1];
                  q_arg[j]    = q_arg[j - 1];
                  q_delta[j]  = q_delta[j - 1];
               end
               q_handle[i] = it.handle;
               q_arg[i]    = it.argument;
               q_delta[i]  = t[31:0];
               q_count++;
               if (i + 1 < q_count) q_delta[i + 1] = clamp32(longint'(q_delta[i + 1]) - t);
            end
            expected_rsps.push_back(r);
         end
         dlq_pkg::OP_REMOVE: begin
            r.status = dlq_pkg::ST_NOT_FOUND;
            for (i = 0; i < q_count; i++) begin
               if (q_handle[i] == it.handle && q_arg[i] == it.argument) begin
                  if (i + 1 < q_count && q_delta[i] > 0)
                     q_delta[i + 1] = clamp32(longint'(q_delta[i + 1]) + q_delta[i]);
                  shift_down(i);
                  r.status = dlq_pkg::ST_OK;
                  break;
               end
            end
            expected_rsps.push_back(r);
         end
         dlq_pkg::OP_TICK: begin
            for (i = 0; i < q_count; i++) begin
               q_delta[i] = clamp32(longint'(q_delta[i]) - 1);
               if (q_delta[i] > 0) break;
               r.due_flag = 1'b1;
               if (q_delta[i] == 0) break;
            end
            expected_rsps.push_back(r);
         end
         default: begin
            n = 0;
            while (n < dlq_pkg::MAX_RESULTS && q_count > 0 && q_delta[0] <= 0) begin
               r = '0;
               r.entry_valid  = 1'b1;
               r.out_handle   = q_handle[0];
               r.out_argument = q_arg[0];
               r.lateness     = q_delta[0];
               shift_down(0);
               n++;
               r.last = !(n < dlq_pkg::MAX_RESULTS && q_count > 0 && q_delta[0] <= 0);
               expected_rsps.push_back(r);
            end
            if (n == 0) begin
               r = '0;
               r.last = 1'b1;
               expected_rsps.push_back(r);
            end
         end
      endcase
   endfunction

   function automatic dlq_pkg::req_item_type make_item(dlq_pkg::opcode_type op,
                                                       logic [15:0] h, logic [31:0] a,
                                                       logic signed [31:0] d);
      dlq_pkg::req_item_type it;
      it.opcode = op;
      it.handle = h;
      it.argument = a;
      it.delay_ticks = d;
      return it;
   endfunction

   // Delay mostly small so entries come due, with occasional extremes
   function automatic logic signed [31:0] rand_delay();
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1:       return -$signed(32'($urandom_range(0, 5)));
         2:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: return $urandom_range(1, 12);
      endcase
   endfunction

   // Stimulus: directed corners, then mixed random traffic
   initial begin
      logic [15:0] h;
      logic [31:0] a;
      logic [15:0] used_h[$];
      logic [31:0] used_a[$];
      int k;
      pending_items.push_back(make_item(dlq_pkg::OP_EXPIRE, 16'h0, 32'h0, 32'sd0));
      pending_items.push_back(make_item(dlq_pkg::OP_TICK, 16'h0, 32'h0, 32'sd0));
      pending_items.push_back(make_item(dlq_pkg::OP_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 32'sd0));
      pending_items.push_back(make_item(dlq_pkg::OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF,
                                        32'sh7FFF_FFFF));
      pending_items.push_back(make_item(dlq_pkg::OP_INSERT, 16'h0000, 32'h0000_0000,
                                        32'sh8000_0000));
      pending_items.push_back(make_item(dlq_pkg::OP_INSERT, 16'h1234, 32'hA5A5_5A5A, 32'sd0));
      pending_items.push_back(make_item(dlq_pkg::OP_INSERT, 16'h0002, 32'h5A5A_A5A5, 32'sd3));
      pending_items.push_back(make_item(dlq_pkg::OP_REMOVE, 16'h1234, 32'hA5A5_5A5A, 32'sd0));
      for (k = 0; k < 5; k++)
         pending_items.push_back(make_item(dlq_pkg::OP_TICK, 16'h0, 32'h0, 32'sd0));
      pending_items.push_back(make_item(dlq_pkg::OP_EXPIRE, 16'h0, 32'h0, 32'sd0));
      // Fill the queue past full with all entries due together
      for (k = 0; k < DEPTH + 1; k++)
         pending_items.push_back(make_item(dlq_pkg::OP_INSERT, k[15:0], ~k, 32'sd1));
      pending_items.push_back(make_item(dlq_pkg::OP_TICK, 16'h0, 32'h0, 32'sd0));
      pending_items.push_back(make_item(dlq_pkg::OP_TICK, 16'h0, 32'h0, 32'sd0));
      pending_items.push_back(make_item(dlq_pkg::OP_EXPIRE, 16'h0, 32'h0, 32'sd0));
      pending_items.push_back(make_item(dlq_pkg::OP_EXPIRE, 16'h0, 32'h0, 32'sd0));
      // Put a short entry ahead of the remaining huge one, tick it overdue and expire it
      pending_items.push_back(make_item(dlq_pkg::OP_INSERT, 16'h7777, 32'h1, 32'sd1));
      pending_items.push_back(make_item(dlq_pkg::OP_TICK, 16'h0, 32'h0, 32'sd0));
      pending_items.push_back(make_item(dlq_pkg::OP_TICK, 16'h0, 32'h0, 32'sd0));
      pending_items.push_back(make_item(dlq_pkg::OP_EXPIRE, 16'h0, 32'h0, 32'sd0));
      wait (!reset);
      for (k = 0; k < 365; k++) begin
         if (k == 150) begin
            // pause until everything outstanding has drained
            wait (pending_items.size() == 0 && !req_valid && expected_rsps.size() == 0);
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               h = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 7));
               a = $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 3));
               used_h.push_back(h);
               used_a.push_back(a);
               pending_items.push_back(make_item(dlq_pkg::OP_INSERT, h, a, rand_delay()));
            end
            4: begin
               if (used_h.size() > 0 && $urandom_range(0, 3) != 0) begin
                  int s;
                  s = $urandom_range(0, used_h.size() - 1);
                  h = used_h[s];
                  a = used_a[s];
               end else begin
                  h = 16'($urandom);
                  a = $urandom;
               end
               pending_items.push_back(make_item(dlq_pkg::OP_REMOVE, h, a, $urandom));
            end
            5, 6, 7:
               pending_items.push_back(make_item(dlq_pkg::OP_TICK, 16'($urandom), $urandom,
                                                 $urandom));
            default:
               pending_items.push_back(make_item(dlq_pkg::OP_EXPIRE, 16'($urandom), $urandom,
                                                 $urandom));
         endcase
         if (k % 40 == 0) @(posedge clock);
      end
      stim_done = 1'b1;
   end

   // Driver: bursts of items with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
         // hold item until accepted
      end else begin
         if (req_valid && req_ready) begin
            predict_timer_op(req_item);
            items_sent++;
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_item  <= pending_items.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 12);
               gap_left   = $urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern, with one long hold-off while the sender keeps going
   int stall_cnt = 0;
   int long_hold = 0;
   bit long_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (long_hold > 0) begin
         long_hold--;
         rsp_ready <= 1'b0;
      end else if (!long_done && items_sent > 60) begin
         long_done = 1'b1;
         long_hold = 400;
         rsp_ready <= 1'b0;
      end else begin
         stall_cnt++;
         case ((stall_cnt / 200) % 3)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= (stall_cnt % 5) != 0;
            default: rsp_ready <= $urandom_range(0, 2) != 0;
         endcase
      end
   end

   // Monitor: compare every accepted result with the oldest expectation
   always @(posedge clock) begin
      dlq_pkg::rsp_item_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         rsps_seen++;
         if (rsp_item.entry_valid) pops_seen++;
         if (expected_rsps.size() == 0) begin
            $error("unexpected result item %p", rsp_item);
            error_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_item.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_item.status);
               error_count++;
            end
            if (rsp_item.due_flag !== e.due_flag) begin
               $error("due_flag exp %0d got %0d", e.due_flag, rsp_item.due_flag);
               error_count++;
            end
            if (rsp_item.entry_valid !== e.entry_valid) begin
               $error("entry_valid exp %0d got %0d", e.entry_valid, rsp_item.entry_valid);
               error_count++;
            end
            if (rsp_item.out_handle !== e.out_handle) begin
               $error("out_handle exp %h got %h", e.out_handle, rsp_item.out_handle);
               error_count++;
            end
            if (rsp_item.out_argument !== e.out_argument) begin
               $error("out_argument exp %h got %h", e.out_argument, rsp_item.out_argument);
               error_count++;
            end
            if (rsp_item.lateness !== e.lateness) begin
               $error("lateness exp %0d got %0d", e.lateness, rsp_item.lateness);
               error_count++;
            end
            if (rsp_item.last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_item.last);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("delta_list_timer_queue test failed");
         $finish;
      end
   end

   // Reset, then wait for drain and finish
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && pending_items.size() == 0);
      @(posedge clock);
      while (req_valid || expected_rsps.size() != 0) @(posedge clock);
      repeat (2 * DEPTH + 10) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $error("%0d expected results never arrived", expected_rsps.size());
         error_count++;
      end
      $display("Ran %0d timer operations, checked %0d results including %0d expired entries.",
               items_sent, rsps_seen, pops_seen);
      if (error_count == 0) begin
         $display("delta_list_timer_queue test passed");
      end else begin
         $display("delta_list_timer_queue test failed");
      end
      $finish;
   end
endmodule

@@ delta_list_timer_queue.f @@
rtl/core/dlq_pkg.sv
rtl/core/dlq_cell.sv
rtl/core/dlq_ctrl.sv
rtl/core/delta_list_timer_queue.sv
tb/sv/delta_list_timer_queue_tb.sv
